>>> src/sf3p_pkg.sv
// ----------------------------------------------------------------------------
// sf3p_pkg
// Types, widths and helpers for the three-point segment frame block.
// ----------------------------------------------------------------------------
`default_nettype none

package sf3p_pkg;

   // coordinate and intermediate widths
   localparam int CW   = 32;   // Q16.16 coordinate
   localparam int DW   = 33;   // point difference
   localparam int UW   = 66;   // ox.ox and |ox.oy|
   localparam int VW   = 67;   // signed ox.oy
   localparam int PW   = 65;   // projection partial product
   localparam int NW   = 98;   // projection numerator
   localparam int QW   = 34;   // projection quotient bits
   localparam int OYW  = 36;   // corrected y axis
   localparam int OYL  = 18;   // low slice of oy for cross products
   localparam int PLW  = 52;   // dx times low slice
   localparam int PHW  = 51;   // dx times high slice
   localparam int PPW  = 69;   // full cross product term
   localparam int TW   = 70;   // cross product difference
   localparam int OZW  = 36;   // z axis
   localparam int SW   = 37;   // end point sum before saturation

   // magnitude cap for the z axis after the Q32.32 to Q16.16 shift
   localparam logic [34:0] OZ_CAP = 35'h4_0000_0000;

   // axis codes
   typedef logic [1:0] sf3p_axis_type;
   localparam sf3p_axis_type AXIS_X = 2'd0;
   localparam sf3p_axis_type AXIS_Y = 2'd1;
   localparam sf3p_axis_type AXIS_Z = 2'd2;

   // input item
   typedef struct packed {
      logic signed [CW-1:0] origin_x;
      logic signed [CW-1:0] origin_y;
      logic signed [CW-1:0] origin_z;
      logic signed [CW-1:0] long_x;
      logic signed [CW-1:0] long_y;
      logic signed [CW-1:0] long_z;
      logic signed [CW-1:0] plane_x;
      logic signed [CW-1:0] plane_y;
      logic signed [CW-1:0] plane_z;
      logic                 missing;
   } sf3p_req_type;

   // result item
   typedef struct packed {
      sf3p_axis_type        axis;
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] start_z;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] end_z;
      logic                 drop;
      logic                 last;
   } sf3p_rsp_type;

   // per-item values that ride along the pipeline
   typedef struct packed {
      logic                   drop;
      logic [2:0]             pneg;
      logic [2:0][CW-1:0]     org;
      logic [2:0][DW-1:0]     dx;
      logic [2:0][DW-1:0]     dy;
   } sf3p_side_type;

   // saturate a widened sum to the signed 32 bit range
   function automatic logic [CW-1:0] sat32(input logic signed [SW-1:0] v);
      logic [SW-CW:0] top;
      top = v[SW-1:CW-1];
      if (top == '0 || top == '1) begin
         return v[CW-1:0];
      end else if (v[SW-1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

>>> src/sf3p_div.sv
// ----------------------------------------------------------------------------
// sf3p_div
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage; a side struct travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3p_div import sf3p_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [2:0][NW-1:0]    in_num,
   input  wire logic [UW-1:0]         in_den,
   input  wire sf3p_side_type         in_side,
   output      logic                  out_valid,
   output      logic [2:0][QW-1:0]    out_quo,
   output      sf3p_side_type         out_side
);

   logic                  vld_ff  [QW+1];
   logic [2:0][UW-1:0]    rem_ff  [QW+1];
   logic [2:0][QW-1:0]    low_ff  [QW+1];
   logic [2:0][QW-1:0]    quo_ff  [QW+1];
   logic [UW-1:0]         den_ff  [QW+1];
   sf3p_side_type         side_ff [QW+1];

   // load: quotient is known to fit QW bits, so the top part is the first remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      for (int l = 0; l < 3; l++) begin
         rem_ff[0][l] <= UW'(in_num[l][NW-1:QW]);
         low_ff[0][l] <= in_num[l][QW-1:0];
         quo_ff[0][l] <= '0;
      end
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [2:0][UW-1:0] rem_in;
      logic [2:0][QW-1:0] quo_in;

      always_comb begin
         logic [UW:0] sh;
         for (int l = 0; l < 3; l++) begin
            sh = {rem_ff[k][l], low_ff[k][l][QW-1-k]};
            if (sh >= {1'b0, den_ff[k]}) begin
               rem_in[l] = UW'(sh - {1'b0, den_ff[k]});
               quo_in[l] = {quo_ff[k][l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = sh[UW-1:0];
               quo_in[l] = {quo_ff[k][l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         low_ff[k+1]  <= low_ff[k];
         quo_ff[k+1]  <= quo_in;
         den_ff[k+1]  <= den_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_side  = side_ff[QW];

`ifndef ASSERT_OFF
   // first remainder already below the divisor (quotient fits)
   a_rem_init: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !side_ff[0].drop |->
         rem_ff[0][0] < den_ff[0] && rem_ff[0][1] < den_ff[0] && rem_ff[0][2] < den_ff[0])
      else $error("sf3p_div: initial remainder not below divisor");

   // final remainder below the divisor
   a_rem_done: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QW] && !side_ff[QW].drop |->
         rem_ff[QW][0] < den_ff[QW] && rem_ff[QW][1] < den_ff[QW] &&
         rem_ff[QW][2] < den_ff[QW])
      else $error("sf3p_div: final remainder not below divisor");

   // projection is bounded by the plane vector, so the top quotient bit stays clear
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QW] && !side_ff[QW].drop |->
         !quo_ff[QW][0][QW-1] && !quo_ff[QW][1][QW-1] && !quo_ff[QW][2][QW-1])
      else $error("sf3p_div: projection quotient out of range");
`endif

endmodule

`default_nettype wire

>>> src/segment_frame_from_three_points_top.sv
// ----------------------------------------------------------------------------
// segment_frame_from_three_points_top
// Builds an unnormalized orthogonal frame from origin, long-axis and
// plane-axis points and emits one line item per axis, or one drop item.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. busy stays high after
// each accept until the cool-down counter runs out, which gives the output
// serializer the time it needs to put the three axis lines out one per cycle.
// The arithmetic is a fully pipelined datapath (dot products, a 34-stage
// projection divider, cross products, saturation): the first result of an
// item leaves on rsp_valid after stages a to g, the divider, stages h to n and
// the output register, and the other two follow back to back; a drop item
// (missing point or long point equal to origin) gives a single result with
// drop and last set. The result strobe is one cycle wide and cannot be held off.
`default_nettype none

module segment_frame_from_three_points_top import sf3p_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output      logic          busy,
   input  wire sf3p_req_type  req_data,
   output      logic          rsp_valid,
   output      sf3p_rsp_type  rsp_data
);

   // accept pacing
   logic [1:0] cool_ff, cool_in;
   logic       accept;

   assign busy   = (cool_ff != 2'd0);
   assign accept = start && !busy;

   always_comb begin
      if (accept) begin
         cool_in = 2'd2;
      end else if (cool_ff != 2'd0) begin
         cool_in = cool_ff - 2'd1;
      end else begin
         cool_in = 2'd0;
      end
   end

   // ---------------------------------------------------------------- stage a
   logic [2:0][CW-1:0] org_w, lng_w, pln_w;
   sf3p_side_type      sa_in;

   assign org_w = {req_data.origin_z, req_data.origin_y, req_data.origin_x};
   assign lng_w = {req_data.long_z, req_data.long_y, req_data.long_x};
   assign pln_w = {req_data.plane_z, req_data.plane_y, req_data.plane_x};

   // differences to the origin; zero-length long axis means drop
   always_comb begin
      sa_in.org  = org_w;
      sa_in.pneg = '0;
      sa_in.drop = req_data.missing || (lng_w == org_w);
      for (int i = 0; i < 3; i++) begin
         sa_in.dx[i] = DW'($signed(lng_w[i])) - DW'($signed(org_w[i]));
         sa_in.dy[i] = DW'($signed(pln_w[i])) - DW'($signed(org_w[i]));
      end
   end

   logic          va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff;
   sf3p_side_type sa_ff, sb_ff, sc_ff, sd_ff, se_ff, sf_ff, sg_ff;

   // ---------------------------------------------------------------- stage b
   logic [CW-1:0] adx_in [3];
   logic [CW-1:0] adx_b_ff [3], adx_c_ff [3], adx_d_ff [3], adx_e_ff [3];

   // long axis magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         adx_in[i] = sa_ff.dx[i][DW-1] ? CW'(DW'(0) - sa_ff.dx[i]) : sa_ff.dx[i][CW-1:0];
      end
   end

   // ---------------------------------------------------------------- stage c
   logic [2*CW-1:0] sq_in [3], sq_c_ff [3];
   logic [UW-1:0]   pr_in [3], pr_c_ff [3];

   // squares and mixed products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2*CW)'(adx_b_ff[i]) * (2*CW)'(adx_b_ff[i]);
         pr_in[i] = UW'($signed(sb_ff.dx[i])) * UW'($signed(sb_ff.dy[i]));
      end
   end

   // ---------------------------------------------------------------- stage d
   logic [UW-1:0] uu_in, uu_d_ff, uu_e_ff, uu_f_ff, uu_g_ff;
   logic [VW-1:0] uv_in, uv_d_ff;

   // dot products ox.ox and ox.oy
   assign uu_in = UW'(sq_c_ff[0]) + UW'(sq_c_ff[1]) + UW'(sq_c_ff[2]);
   assign uv_in = VW'($signed(pr_c_ff[0])) + VW'($signed(pr_c_ff[1]))
                + VW'($signed(pr_c_ff[2]));

   // ---------------------------------------------------------------- stage e
   logic [UW-1:0] uvm_in, uvm_e_ff;
   logic          uvneg_e_ff;

   assign uvm_in = UW'(uv_d_ff[VW-1] ? (VW'(0) - uv_d_ff) : uv_d_ff);

   // ---------------------------------------------------------------- stage f
   logic [PW-1:0] pl_in [3], ph_in [3], pl_f_ff [3], ph_f_ff [3];
   sf3p_side_type sf_in;

   // numerator partial products |ox.oy| * |ox_i|, split at bit 33
   always_comb begin
      sf_in = se_ff;
      for (int i = 0; i < 3; i++) begin
         pl_in[i] = PW'(uvm_e_ff[32:0]) * PW'(adx_e_ff[i]);
         ph_in[i] = PW'(uvm_e_ff[UW-1:33]) * PW'(adx_e_ff[i]);
         sf_in.pneg[i] = uvneg_e_ff ^ se_ff.dx[i][DW-1];
      end
   end

   // ---------------------------------------------------------------- stage g
   logic [2:0][NW-1:0] num_in, num_g_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {ph_f_ff[i], 33'b0} + NW'(pl_f_ff[i]);
      end
   end

   // front pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cool_ff <= 2'd0;
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         vd_ff   <= 1'b0;
         ve_ff   <= 1'b0;
         vf_ff   <= 1'b0;
         vg_ff   <= 1'b0;
      end else begin
         cool_ff <= cool_in;
         va_ff   <= accept;
         vb_ff   <= va_ff;
         vc_ff   <= vb_ff;
         vd_ff   <= vc_ff;
         ve_ff   <= vd_ff;
         vf_ff   <= ve_ff;
         vg_ff   <= vf_ff;
      end
      sa_ff <= sa_in;
      sb_ff <= sa_ff;
      sc_ff <= sb_ff;
      sd_ff <= sc_ff;
      se_ff <= sd_ff;
      sf_ff <= sf_in;
      sg_ff <= sf_ff;
      adx_b_ff <= adx_in;
      adx_c_ff <= adx_b_ff;
      adx_d_ff <= adx_c_ff;
      adx_e_ff <= adx_d_ff;
      sq_c_ff  <= sq_in;
      pr_c_ff  <= pr_in;
      uu_d_ff  <= uu_in;
      uv_d_ff  <= uv_in;
      uu_e_ff  <= uu_d_ff;
      uvm_e_ff <= uvm_in;
      uvneg_e_ff <= uv_d_ff[VW-1];
      uu_f_ff  <= uu_e_ff;
      pl_f_ff  <= pl_in;
      ph_f_ff  <= ph_in;
      uu_g_ff  <= uu_f_ff;
      num_g_ff <= num_in;
   end

   // ------------------------------------------------------- projection divide
   logic               vq;
   logic [2:0][QW-1:0] quo_q;
   sf3p_side_type      sq_w;

   sf3p_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vg_ff),
      .in_num    (num_g_ff),
      .in_den    (uu_g_ff),
      .in_side   (sg_ff),
      .out_valid (vq),
      .out_quo   (quo_q),
      .out_side  (sq_w)
   );

   logic          vh_ff, vi_ff, vj_ff, vk_ff, vl_ff, vm_ff, vn_ff;
   sf3p_side_type sh_ff, si_ff, sj_ff, sk_ff, sl_ff, sm_ff;

   // ---------------------------------------------------------------- stage h
   logic signed [OYW-1:0] oy_in [3];
   logic signed [OYW-1:0] oy_h_ff [3], oy_i_ff [3], oy_j_ff [3], oy_k_ff [3];
   logic signed [OYW-1:0] oy_l_ff [3], oy_m_ff [3];

   // remove the projection: oy - p
   always_comb begin
      logic signed [OYW-1:0] dyx;
      logic signed [OYW-1:0] qx;
      for (int i = 0; i < 3; i++) begin
         dyx = OYW'($signed(sq_w.dy[i]));
         qx  = $signed(OYW'(quo_q[i]));
         oy_in[i] = sq_w.pneg[i] ? (dyx + qx) : (dyx - qx);
      end
   end

   // ---------------------------------------------------------------- stage i
   logic signed [PLW-1:0] pal_in [3], pbl_in [3], pal_i_ff [3], pbl_i_ff [3];
   logic signed [PHW-1:0] pah_in [3], pbh_in [3], pah_i_ff [3], pbh_i_ff [3];

   // cross product partials, oy split into a low and a signed high slice
   always_comb begin
      int a;
      int b;
      for (int i = 0; i < 3; i++) begin
         a = (i == 2) ? 0 : i + 1;
         b = (i == 0) ? 2 : i - 1;
         pal_in[i] = PLW'($signed(sh_ff.dx[a])) * PLW'($signed({1'b0, oy_h_ff[b][OYL-1:0]}));
         pah_in[i] = PHW'($signed(sh_ff.dx[a])) * PHW'($signed(oy_h_ff[b][OYW-1:OYL]));
         pbl_in[i] = PLW'($signed(sh_ff.dx[b])) * PLW'($signed({1'b0, oy_h_ff[a][OYL-1:0]}));
         pbh_in[i] = PHW'($signed(sh_ff.dx[b])) * PHW'($signed(oy_h_ff[a][OYW-1:OYL]));
      end
   end

   // ---------------------------------------------------------------- stage j
   logic signed [PPW-1:0] pab_in [3], pba_in [3], pab_j_ff [3], pba_j_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pab_in[i] = $signed({pah_i_ff[i], {OYL{1'b0}}}) + PPW'(pal_i_ff[i]);
         pba_in[i] = $signed({pbh_i_ff[i], {OYL{1'b0}}}) + PPW'(pbl_i_ff[i]);
      end
   end

   // ---------------------------------------------------------------- stage k
   logic signed [TW-1:0] t_in [3], t_k_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = TW'(pab_j_ff[i]) - TW'(pba_j_ff[i]);
      end
   end

   // ---------------------------------------------------------------- stage l
   logic [TW-1:0] tm_in [3], tm_l_ff [3];
   logic [2:0]    tneg_l_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tm_in[i] = t_k_ff[i][TW-1] ? (TW'(0) - $unsigned(t_k_ff[i])) : $unsigned(t_k_ff[i]);
      end
   end

   // ---------------------------------------------------------------- stage m
   logic [OZW-1:0] oz_in [3], oz_m_ff [3];

   // back to Q16.16 by truncating the magnitude, then cap and re-sign
   always_comb begin
      logic [TW-17:0] m;
      logic [34:0]    mc;
      for (int i = 0; i < 3; i++) begin
         m  = tm_l_ff[i][TW-1:16];
         mc = (m > (TW-16)'(OZ_CAP)) ? OZ_CAP : m[34:0];
         oz_in[i] = tneg_l_ff[i] ? (OZW'(0) - OZW'(mc)) : OZW'(mc);
      end
   end

   // ---------------------------------------------------------------- stage n
   logic [2:0][CW-1:0] end_in [3];
   logic [2:0][CW-1:0] end_n_ff [3];
   logic [2:0][CW-1:0] org_n_ff;
   logic               drop_n_ff;

   // line ends, saturated
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         end_in[0][c] = sat32(SW'($signed(sm_ff.dx[c])) + SW'($signed(sm_ff.org[c])));
         end_in[1][c] = sat32(SW'(oy_m_ff[c]) + SW'($signed(sm_ff.org[c])));
         end_in[2][c] = sat32(SW'($signed(oz_m_ff[c])) + SW'($signed(sm_ff.org[c])));
      end
   end

   // back pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
         vj_ff <= 1'b0;
         vk_ff <= 1'b0;
         vl_ff <= 1'b0;
         vm_ff <= 1'b0;
         vn_ff <= 1'b0;
      end else begin
         vh_ff <= vq;
         vi_ff <= vh_ff;
         vj_ff <= vi_ff;
         vk_ff <= vj_ff;
         vl_ff <= vk_ff;
         vm_ff <= vl_ff;
         vn_ff <= vm_ff;
      end
      sh_ff <= sq_w;
      si_ff <= sh_ff;
      sj_ff <= si_ff;
      sk_ff <= sj_ff;
      sl_ff <= sk_ff;
      sm_ff <= sl_ff;
      oy_h_ff <= oy_in;
      oy_i_ff <= oy_h_ff;
      oy_j_ff <= oy_i_ff;
      oy_k_ff <= oy_j_ff;
      oy_l_ff <= oy_k_ff;
      oy_m_ff <= oy_l_ff;
      pal_i_ff <= pal_in;
      pah_i_ff <= pah_in;
      pbl_i_ff <= pbl_in;
      pbh_i_ff <= pbh_in;
      pab_j_ff <= pab_in;
      pba_j_ff <= pba_in;
      t_k_ff   <= t_in;
      tm_l_ff  <= tm_in;
      for (int i = 0; i < 3; i++) begin
         tneg_l_ff[i] <= t_k_ff[i][TW-1];
      end
      oz_m_ff  <= oz_in;
      end_n_ff <= end_in;
      org_n_ff <= sm_ff.org;
      drop_n_ff <= sm_ff.drop;
   end

   // ------------------------------------------------------- output serializer
   logic               act_ff, act_in;
   sf3p_axis_type      idx_ff, idx_in;
   logic [2:0][CW-1:0] fr_org_ff;
   logic [2:0][CW-1:0] fr_end_ff [3];
   logic               rsp_valid_ff, rsp_valid_in;
   sf3p_rsp_type       rsp_ff, rsp_in;

   // x line as the frame leaves the pipeline, then y and z from the frame hold
   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      act_in       = act_ff;
      idx_in       = idx_ff;
      if (vn_ff) begin
         rsp_valid_in = 1'b1;
         if (drop_n_ff) begin
            rsp_in.drop = 1'b1;
            rsp_in.last = 1'b1;
         end else begin
            rsp_in.axis    = AXIS_X;
            rsp_in.start_x = org_n_ff[0];
            rsp_in.start_y = org_n_ff[1];
            rsp_in.start_z = org_n_ff[2];
            rsp_in.end_x   = end_n_ff[0][0];
            rsp_in.end_y   = end_n_ff[0][1];
            rsp_in.end_z   = end_n_ff[0][2];
            act_in = 1'b1;
            idx_in = AXIS_Y;
         end
      end else if (act_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_in.axis    = idx_ff;
         rsp_in.start_x = fr_org_ff[0];
         rsp_in.start_y = fr_org_ff[1];
         rsp_in.start_z = fr_org_ff[2];
         rsp_in.end_x   = fr_end_ff[idx_ff][0];
         rsp_in.end_y   = fr_end_ff[idx_ff][1];
         rsp_in.end_z   = fr_end_ff[idx_ff][2];
         rsp_in.last    = (idx_ff == AXIS_Z);
         if (idx_ff == AXIS_Z) begin
            act_in = 1'b0;
         end else begin
            idx_in = AXIS_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         idx_ff       <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (vn_ff) begin
         fr_org_ff <= org_n_ff;
         fr_end_ff <= end_n_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // accepted item closes the door for the next cycle
   a_pace: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("sf3p: busy not raised after accept");

   // a new frame never arrives while the serializer is still sending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      vn_ff |-> !act_ff)
      else $error("sf3p: frame arrived while serializer active");

   // drop is a lone item
   a_drop_lone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drop |-> rsp_data.last && rsp_data.axis == AXIS_X)
      else $error("sf3p: malformed drop item");

   // z line closes the item, and only it
   a_last_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.drop |-> rsp_data.last == (rsp_data.axis == AXIS_Z))
      else $error("sf3p: last flag misplaced");
`endif

endmodule

`default_nettype wire

>>> dv/segment_frame_from_three_points_top_tb.sv
// ----------------------------------------------------------------------------
// segment_frame_from_three_points_top_tb
// Self-checking bench: drives point triples through the command port,
// predicts the axis lines or drop item of each one, and compares every
// result strobe in order against the expected queue.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_frame_from_three_points_top_tb import sf3p_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // number of random items
   localparam int N_RANDOM = 420;
   // drain wait, above the pipeline depth from accept to the last result
   localparam int LATENCY  = 60;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   sf3p_req_type  req_data;
   logic          rsp_valid;
   sf3p_rsp_type  rsp_data;

   int            n_errors;
   int            n_drop_items;
   int            n_frame_items;

   segment_frame_from_three_points_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // single line per mismatch, counted
   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("ERROR %0t: %s", $realtime, msg);
   endtask

   // saturate to signed 32 bits
   function automatic logic [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fff_ffff;
      if (v < -128'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // clamp magnitude, keep sign
   function automatic logic signed [127:0] cap_mag(input logic signed [127:0] v,
                                                  input logic signed [127:0] cap);
      logic signed [127:0] m;
      m = (v < 0) ? -v : v;
      if (m > cap) m = cap;
      return (v < 0) ? -m : m;
   endfunction

   // frame lines expected for one item
   class frame_scoreboard;
      sf3p_rsp_type lines_due[$];

      function void note_item(input sf3p_req_type r);
         logic signed [127:0] org [3];
         logic signed [127:0] dx [3];
         logic signed [127:0] dy [3];
         logic signed [127:0] oy [3];
         logic signed [127:0] oz [3];
         logic signed [127:0] uu, uv, p, t, m;
         sf3p_rsp_type ln;
         int a, b;
         org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
         dx[0] = 128'(r.long_x) - org[0];
         dx[1] = 128'(r.long_y) - org[1];
         dx[2] = 128'(r.long_z) - org[2];
         dy[0] = 128'(r.plane_x) - org[0];
         dy[1] = 128'(r.plane_y) - org[1];
         dy[2] = 128'(r.plane_z) - org[2];
         uu = 0; uv = 0;
         for (int i = 0; i < 3; i++) begin
            uu += dx[i] * dx[i];
            uv += dx[i] * dy[i];
         end
         // missing point or degenerate long axis
         if (r.missing || uu == 0) begin
            ln = '0;
            ln.drop = 1'b1;
            ln.last = 1'b1;
            lines_due.push_back(ln);
            n_drop_items++;
            return;
         end
         n_frame_items++;
         // remove projection, truncating toward zero
         for (int i = 0; i < 3; i++) begin
            m = uv * dx[i];
            p = ((m < 0) ? -m : m) / uu;
            if (p > (128'sd1 <<< 40)) p = 128'sd1 <<< 40;
            if (m < 0) p = -p;
            oy[i] = dy[i] - p;
         end
         // cross product, magnitude shifted down by 16
         for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            t = dx[a] * oy[b] - dx[b] * oy[a];
            m = ((t < 0) ? -t : t) >>> 16;
            oz[i] = cap_mag((t < 0) ? -m : m, 128'sd1 <<< 34);
         end
         for (int k = 0; k < 3; k++) begin
            ln = '0;
            ln.axis    = (k == 0) ? AXIS_X : ((k == 1) ? AXIS_Y : AXIS_Z);
            ln.start_x = r.origin_x;
            ln.start_y = r.origin_y;
            ln.start_z = r.origin_z;
            ln.end_x = clamp32(org[0] + (k == 0 ? dx[0] : (k == 1 ? oy[0] : oz[0])));
            ln.end_y = clamp32(org[1] + (k == 0 ? dx[1] : (k == 1 ? oy[1] : oz[1])));
            ln.end_z = clamp32(org[2] + (k == 0 ? dx[2] : (k == 1 ? oy[2] : oz[2])));
            ln.last = (k == 2);
            lines_due.push_back(ln);
         end
      endfunction

      task check_line(input sf3p_rsp_type got);
         sf3p_rsp_type w;
         if (lines_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
         end
         w = lines_due.pop_front();
         if (got.axis !== w.axis)
            report_mismatch($sformatf("axis %0d want %0d", got.axis, w.axis));
         if (got.start_x !== w.start_x || got.start_y !== w.start_y ||
             got.start_z !== w.start_z)
            report_mismatch($sformatf("start %h %h %h want %h %h %h", got.start_x,
                            got.start_y, got.start_z, w.start_x, w.start_y, w.start_z));
         if (got.end_x !== w.end_x)
            report_mismatch($sformatf("axis %0d end_x %h want %h", w.axis, got.end_x, w.end_x));
         if (got.end_y !== w.end_y)
            report_mismatch($sformatf("axis %0d end_y %h want %h", w.axis, got.end_y, w.end_y));
         if (got.end_z !== w.end_z)
            report_mismatch($sformatf("axis %0d end_z %h want %h", w.axis, got.end_z, w.end_z));
         if (got.drop !== w.drop || got.last !== w.last)
            report_mismatch($sformatf("drop/last %b%b want %b%b", got.drop, got.last,
                            w.drop, w.last));
      endtask
   endclass

   frame_scoreboard frames;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("segment_frame_from_three_points_top_tb: FAIL");
      $finish;
   end

   // accepted items and results, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) frames.note_item(req_data);
         if (rsp_valid) frames.check_line(rsp_data);
      end
   end

   // random coordinate: extremes, small values or full range
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic sf3p_req_type rand_item();
      sf3p_req_type r;
      r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
      r.long_x   = rand_coord(); r.long_y   = rand_coord(); r.long_z   = rand_coord();
      r.plane_x  = rand_coord(); r.plane_y  = rand_coord(); r.plane_z  = rand_coord();
      // occasional degenerate long axis or plane point
      if ($urandom_range(0, 19) == 0) begin
         r.long_x = r.origin_x; r.long_y = r.origin_y; r.long_z = r.origin_z;
      end
      if ($urandom_range(0, 19) == 0) begin
         r.plane_x = r.long_x; r.plane_y = r.long_y; r.plane_z = r.long_z;
      end
      r.missing = ($urandom_range(0, 9) == 0);
      return r;
   endfunction

   // present one item and hold it until accepted
   task automatic send_item(input sf3p_req_type r);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      start    <= 1'b0;
      req_data <= '0;
      repeat ($urandom_range(1, 8)) @(negedge clock);
   endtask

   task automatic directed_items();
      sf3p_req_type r;
      // all zero: degenerate long axis
      r = '0;
      send_item(r);
      // missing with nonzero points
      r = '0; r.long_x = 32'h0001_0000; r.missing = 1'b1;
      send_item(r);
      // unit frame
      r = '0; r.long_x = 32'h0001_0000; r.plane_y = 32'h0001_0000;
      send_item(r);
      // plane point on the long axis
      r = '0; r.long_x = 32'h0002_0000; r.plane_x = 32'h0005_0000;
      send_item(r);
      // extremes, saturation both ways
      r = '0;
      r.origin_x = 32'h8000_0000; r.origin_y = 32'h7fff_ffff; r.origin_z = 32'h8000_0000;
      r.long_x = 32'h7fff_ffff; r.long_y = 32'h8000_0000; r.long_z = 32'h7fff_ffff;
      r.plane_x = 32'h8000_0000; r.plane_y = 32'h8000_0000; r.plane_z = 32'h7fff_ffff;
      send_item(r);
      r.origin_x = 32'h7fff_ffff; r.origin_y = 32'h8000_0000; r.origin_z = 32'h7fff_ffff;
      r.long_x = 32'h8000_0000; r.long_y = 32'h7fff_ffff; r.long_z = 32'h8000_0000;
      r.plane_x = 32'h7fff_ffff; r.plane_y = 32'h7fff_ffff; r.plane_z = 32'h8000_0000;
      send_item(r);
      r = '1;
      send_item(r);
      r.missing = 1'b0;
      r.long_x = 32'h0000_0000;
      send_item(r);
      // smallest nonzero long axis
      r = '0; r.long_z = 32'h0000_0001; r.plane_x = 32'h7fff_ffff;
      send_item(r);
      // missing at extremes
      r = '0; r.origin_x = 32'h7fff_ffff; r.long_x = 32'h8000_0000; r.missing = 1'b1;
      send_item(r);
      pause_sender();
   endtask

   initial begin
      int sent;
      int burst;
      frames = new();
      n_errors = 0;
      n_drop_items = 0;
      n_frame_items = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_items();

      // random items in bursts with gaps; some bursts run back to back
      sent = 0;
      while (sent < N_RANDOM) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
            send_item(rand_item());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender();
      end
      start    <= 1'b0;
      req_data <= '0;

      // drain
      while (frames.lines_due.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);

      $display("covered %0d frame items and %0d drop items",
               n_frame_items, n_drop_items);
      if (n_errors == 0) begin
         $display("segment_frame_from_three_points_top_tb: PASS");
      end else begin
         $display("segment_frame_from_three_points_top_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
